// File: design/fircf_pkg.sv
// Shared types and constants for the FIR convolution filter.
// Used by fircf_taps and fir_convolution_filter; depends on nothing else.
package fircf_pkg;

    // Fixed field widths of the filter.
    localparam int COEF_BITS      = 16;
    localparam int OUT_BITS       = 34;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int NUM_COEF       = 7;
    localparam int N_BITS         = 3;
    localparam int CFG_INDEX_BITS = 4;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [OUT_BITS-1:0]  acc_t;
    typedef logic [N_BITS-1:0]           tap_num_t;
    typedef logic [CFG_INDEX_BITS-1:0]   cfg_index_t;

    // Register map of the configuration channel.
    localparam cfg_index_t CFG_TAP_COUNT = 4'd0;
    localparam cfg_index_t CFG_COEF_BASE = 4'd1;

    // Values after reset.
    localparam tap_num_t TAP_COUNT_RESET = 3'd1;
    localparam coef_t    COEF0_RESET     = 16'sd32767;
    localparam coef_t    COEF_RESET      = 16'sd0;

    // Controls for one shift of the delay line.
    typedef struct packed {
        logic push;   // shift a new value in and load the products
        logic clear;  // zero the delay line after this shift
    } push_ctl_t;

endpackage

// File: design/fircf_taps.sv
// Delay line and registered tap products of the FIR convolution filter.
// Depends on fircf_pkg for types and the push control struct.
module fircf_taps #(
    parameter int ACT         = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fircf_pkg::push_ctl_t          ctl,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  fircf_pkg::tap_num_t           n_use,
    input  fircf_pkg::coef_t              coef [ACT],
    output fircf_pkg::acc_t               prod [ACT]
);

    localparam int PROD_BITS = SAMPLE_BITS + fircf_pkg::COEF_BITS;
    localparam int WIDE_BITS = (PROD_BITS > fircf_pkg::OUT_BITS) ? PROD_BITS
                                                                 : fircf_pkg::OUT_BITS;

    logic signed [SAMPLE_BITS-1:0] dl_reg  [ACT-1];
    logic signed [SAMPLE_BITS-1:0] dl_next [ACT-1];
    logic signed [SAMPLE_BITS-1:0] win     [ACT];
    fircf_pkg::acc_t               prod_reg  [ACT];
    fircf_pkg::acc_t               prod_next [ACT];

    always_comb
    begin
        logic signed [PROD_BITS-1:0] full;
        logic signed [WIDE_BITS-1:0] wide;
        full = '0;
        wide = '0;
        win[0] = x;
        for (int i = 1; i < ACT; i++)
        begin
            win[i] = dl_reg[i-1];
        end
        for (int i = 0; i < ACT; i++)
        begin
            full = win[i] * coef[i];
            wide = WIDE_BITS'(full);
            // Taps beyond the count in use contribute nothing.
            if (i < int'(n_use))
            begin
                prod_next[i] = wide[fircf_pkg::OUT_BITS-1:0];
            end
            else
            begin
                prod_next[i] = '0;
            end
        end
        for (int i = 0; i < ACT - 1; i++)
        begin
            dl_next[i] = ctl.clear ? '0 : win[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACT - 1; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (ctl.push)
        begin
            dl_reg <= dl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: design/fir_convolution_filter.sv
// Top level of the streaming FIR convolution filter with its register file.
// Depends on fircf_pkg and instantiates fircf_taps.
//
// The block computes the full linear convolution of a sample stream with up
// to seven signed Q1.15 coefficients. Samples arrive as beats on the slave
// stream (s_t*); each beat yields one exact 34-bit sum on the master stream
// (m_t*). A beat with s_tlast set also causes one tail beat fewer than the
// taps in use, each as if a zero sample had been shifted in, and m_tlast
// marks the final beat of the convolution. The delay line is then cleared.
// The configuration channel writes tap_count (index 0) and coef_0..coef_6
// (indexes 1..7); it is always ready and must be used only while idle.
// Throughput is one beat per cycle in both directions unless a stall or a
// tail holds it. Results pass the product and then the result register.
// While tail beats are produced, one per cycle unless the receiver stalls,
// s_tready is low. When the receiver stalls, the result register holds,
// the product register fills behind it, and s_tready falls only once both
// are full. Reset clears the delay line and the pipeline and restores
// tap_count to 1, coef_0 to 32767 and the other coefficients to zero.
module fir_convolution_filter #(
    parameter int TAPS        = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  fircf_pkg::cfg_index_t                cfg_index,
    input  logic [fircf_pkg::COEF_BITS-1:0]      cfg_data,
    // Sample stream. tdata: sample.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                 s_tlast,   // end_of_signal
    // Result stream. tdata: filtered, then zero fill.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fircf_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                                 m_tlast    // last_out
);

    // Only as many taps as there are coefficient registers can ever be used.
    localparam int ACT = (TAPS < fircf_pkg::NUM_COEF) ? TAPS : fircf_pkg::NUM_COEF;

    fircf_pkg::tap_num_t   tap_count_reg, tap_count_next;
    fircf_pkg::coef_t      coef_reg  [ACT];
    fircf_pkg::coef_t      coef_next [ACT];
    fircf_pkg::tap_num_t   n_use;

    fircf_pkg::tap_num_t   tail_cnt_reg, tail_cnt_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  a_last_reg;
    logic                  out_valid_reg;
    fircf_pkg::acc_t       out_data_reg;
    logic                  out_last_reg;

    logic                  out_ready;
    logic                  a_free;
    logic                  tail_active;
    logic                  in_fire;
    logic                  tail_fire;
    logic                  push_last;
    fircf_pkg::push_ctl_t  ctl;
    logic signed [SAMPLE_BITS-1:0] x;
    fircf_pkg::acc_t       prod [ACT];
    fircf_pkg::acc_t       sum;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        tap_count_next = tap_count_reg;
        coef_next      = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fircf_pkg::CFG_TAP_COUNT)
            begin
                tap_count_next = cfg_data[fircf_pkg::N_BITS-1:0];
            end
            for (int i = 0; i < ACT; i++)
            begin
                if (cfg_index == fircf_pkg::CFG_COEF_BASE
                                 + fircf_pkg::CFG_INDEX_BITS'(i))
                begin
                    coef_next[i] = cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fircf_pkg::TAP_COUNT_RESET;
            coef_reg[0]   <= fircf_pkg::COEF0_RESET;
            for (int i = 1; i < ACT; i++)
            begin
                coef_reg[i] <= fircf_pkg::COEF_RESET;
            end
        end
        else
        begin
            tap_count_reg <= tap_count_next;
            coef_reg      <= coef_next;
        end
    end

    // A count of zero acts as one tap, a count above the available taps as
    // all of them.
    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            n_use = fircf_pkg::tap_num_t'(1);
        end
        else if (int'(tap_count_reg) > ACT)
        begin
            n_use = fircf_pkg::tap_num_t'(ACT);
        end
        else
        begin
            n_use = tap_count_reg;
        end
    end

    // Pipeline handshake. The product register moves into the result
    // register whenever the result register is empty or being taken.
    assign out_ready   = !out_valid_reg || m_tready;
    assign a_free      = !a_valid_reg || out_ready;
    assign tail_active = (tail_cnt_reg != '0);
    assign s_tready    = a_free && !tail_active;
    assign in_fire     = s_tvalid && s_tready;
    assign tail_fire   = tail_active && a_free;

    assign x = in_fire ? s_tdata[SAMPLE_BITS-1:0] : '0;

    always_comb
    begin
        ctl.push      = in_fire || tail_fire;
        ctl.clear     = 1'b0;
        push_last     = 1'b0;
        tail_cnt_next = tail_cnt_reg;
        if (in_fire && s_tlast)
        begin
            if (n_use == fircf_pkg::tap_num_t'(1))
            begin
                // A single tap has no tail: this beat ends the convolution.
                ctl.clear = 1'b1;
                push_last = 1'b1;
            end
            else
            begin
                tail_cnt_next = n_use - fircf_pkg::tap_num_t'(1);
            end
        end
        else if (tail_fire)
        begin
            tail_cnt_next = tail_cnt_reg - fircf_pkg::tap_num_t'(1);
            if (tail_cnt_reg == fircf_pkg::tap_num_t'(1))
            begin
                ctl.clear = 1'b1;
                push_last = 1'b1;
            end
        end
    end

    fircf_taps #(
        .ACT         (ACT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_taps (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (x),
        .n_use (n_use),
        .coef  (coef_reg),
        .prod  (prod)
    );

    // The products wrap into the 34-bit result as they are added.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < ACT; i++)
        begin
            sum = sum + prod[i];
        end
    end

    assign a_valid_next = ctl.push || (a_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_cnt_reg  <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tail_cnt_reg <= tail_cnt_next;
            a_valid_reg  <= a_valid_next;
            if (out_ready)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            a_last_reg <= push_last;
        end
        if (a_valid_reg && out_ready)
        begin
            out_data_reg <= sum;
            out_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fircf_pkg::OUT_TDATA_BITS'(unsigned'(out_data_reg));
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // No new sample is taken while the tail is being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_active |-> !s_tready)
        else $error("sample accepted during tail");

    // A stalled result keeps the product register occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && out_valid_reg && !m_tready) |=> a_valid_reg)
        else $error("product lost while result stalled");

    // An end beat with more than one tap starts a tail.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast && n_use != fircf_pkg::tap_num_t'(1))
        |=> tail_cnt_reg != '0)
        else $error("tail not started after end of signal");

    // The tail never runs longer than the filter.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(tail_cnt_reg) < ACT)
        else $error("tail count out of range");

    // Every push lands in the product register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> a_valid_reg)
        else $error("push did not fill the product register");
`endif

endmodule

// File: bench/fir_convolution_filter_test.sv
// Self-checking testbench for the streaming FIR convolution filter.
// Depends on fircf_pkg and fir_convolution_filter; an internal predictor
// computes the expected beats.
module fir_convolution_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS          = 7;
    localparam int SAMPLE_BITS   = 16;
    localparam int RANDOM_ITEMS  = 410;
    // The slowest legal run is about 450 beats, each with up to seven results
    // and each result behind a long stall, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One expected beat on the result stream.
    typedef struct {
        fircf_pkg::acc_t filtered;
        logic            last_out;
    } conv_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    fircf_pkg::cfg_index_t                cfg_index;
    logic [fircf_pkg::COEF_BITS-1:0]      cfg_data;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [SAMPLE_BITS-1:0]               s_tdata;    // sample
    logic                                 s_tlast;    // end_of_signal
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [fircf_pkg::OUT_TDATA_BITS-1:0] m_tdata;    // filtered, then zero fill
    logic                                 m_tlast;    // last_out

    fir_convolution_filter #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state: its own copy of the registers and the delay line.
    // taps_hist[0] holds the newest sample.
    fircf_pkg::tap_num_t taps_cfg;
    fircf_pkg::coef_t    coef_reg [fircf_pkg::NUM_COEF];
    sample_t             taps_hist [TAPS];
    conv_result_t        conv_expected [$];
    conv_result_t        want;

    int  error_count;
    int  beats_sent;
    int  beats_checked;
    int  signals_sent;
    int  settings_used;
    int  cycle_count;
    int  stall_left;
    // While set, neither side inserts gaps, so beats run back to back.
    bit  steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic void reset_filter_model();
        taps_cfg = fircf_pkg::TAP_COUNT_RESET;
        for (int i = 0; i < fircf_pkg::NUM_COEF; i++)
            coef_reg[i] = fircf_pkg::COEF_RESET;
        coef_reg[0] = fircf_pkg::COEF0_RESET;
        for (int i = 0; i < TAPS; i++)
            taps_hist[i] = '0;
    endfunction

    // A count of zero acts as a single tap; three bits cannot exceed TAPS.
    function automatic int active_taps();
        return (taps_cfg == '0) ? 1 : int'(taps_cfg);
    endfunction

    function automatic void apply_reg(input fircf_pkg::cfg_index_t idx,
                                      input logic [fircf_pkg::COEF_BITS-1:0] val);
        if (idx == fircf_pkg::CFG_TAP_COUNT)
            taps_cfg = val[fircf_pkg::N_BITS-1:0];
        else if (idx >= fircf_pkg::CFG_COEF_BASE &&
                 idx < fircf_pkg::CFG_COEF_BASE + fircf_pkg::NUM_COEF)
            coef_reg[idx - fircf_pkg::CFG_COEF_BASE] = fircf_pkg::coef_t'(val);
        // Any other index leaves the registers alone.
    endfunction

    // Shift one value into the delay line and return the exact sum.
    function automatic fircf_pkg::acc_t shift_and_sum(input sample_t x);
        longint acc;
        int     n;
        for (int i = TAPS - 1; i > 0; i--)
            taps_hist[i] = taps_hist[i-1];
        taps_hist[0] = x;
        n = active_taps();
        acc = 0;
        for (int i = 0; i < n; i++)
            acc += longint'(taps_hist[i]) * longint'(coef_reg[i]);
        return fircf_pkg::acc_t'(acc);
    endfunction

    // Expected beats for one accepted sample, including the tail that the
    // final sample of a signal flushes out.
    function automatic void predict_sample(input sample_t x, input logic eos);
        conv_result_t r;
        int           n;
        n = active_taps();
        r.filtered = shift_and_sum(x);
        r.last_out = eos && (n == 1);
        conv_expected.insert(conv_expected.size(), r);
        if (eos)
        begin
            for (int t = 1; t < n; t++)
            begin
                r.filtered = shift_and_sum('0);
                r.last_out = (t == n - 1);
                conv_expected.insert(conv_expected.size(), r);
            end
            for (int i = 0; i < TAPS; i++)
                taps_hist[i] = '0;
        end
    endfunction

    //------------------------------------------------------------------
    // Random values
    //------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Values with the extremes of the Q1.15 range mixed in often.
    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result side: random stalls and the checker
    //------------------------------------------------------------------

    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Every accepted result beat is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (conv_expected.size() == 0)
            begin
                $error("unexpected result beat: filtered %0d, last_out %0b",
                       $signed(m_tdata[fircf_pkg::OUT_BITS-1:0]), m_tlast);
                error_count++;
            end
            else
            begin
                want = conv_expected.pop_front();
                beats_checked++;
                if (m_tdata[fircf_pkg::OUT_BITS-1:0] !== want.filtered)
                begin
                    $error("filtered: expected %0d, actual %0d",
                           want.filtered, $signed(m_tdata[fircf_pkg::OUT_BITS-1:0]));
                    error_count++;
                end
                if (m_tlast !== want.last_out)
                begin
                    $error("last_out: expected %0b, actual %0b", want.last_out, m_tlast);
                    error_count++;
                end
                if (m_tdata[fircf_pkg::OUT_TDATA_BITS-1:fircf_pkg::OUT_BITS] !== '0)
                begin
                    $error("tdata fill: expected 0, actual %0h",
                           m_tdata[fircf_pkg::OUT_TDATA_BITS-1:fircf_pkg::OUT_BITS]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d beats still expected.",
                     cycle_count, conv_expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sample side and configuration
    //------------------------------------------------------------------

    // Sends one sample beat. Called at a falling edge; returns at the falling
    // edge after the beat was taken. s_tvalid is left high so that the next
    // beat can follow without a gap; callers that stop sending drop it.
    task automatic send_sample(input sample_t x, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= eos;
        do @(posedge clk); while (!s_tready);
        predict_sample(x, eos);
        beats_sent++;
        if (eos)
            signals_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected beat has come out, then lets
    // the pipeline settle so that it is surely empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (conv_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; only called once the filter has drained.
    task automatic write_reg(input fircf_pkg::cfg_index_t idx,
                             input logic [fircf_pkg::COEF_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_coefs(input logic [fircf_pkg::COEF_BITS-1:0] val);
        for (int c = 0; c < fircf_pkg::NUM_COEF; c++)
            write_reg(fircf_pkg::cfg_index_t'(fircf_pkg::CFG_COEF_BASE + c), val);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Reset values: one tap with coef_0 near one, so the filter is almost a
    // wire. The flagged sample has no tail and carries last_out itself.
    task automatic test_reset_defaults();
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shffff, 1'b1);
        wait_drained();
    endtask

    // Full length with every coefficient at the most negative value, so the
    // products reach both extremes of the sum.
    task automatic test_extremes();
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'(TAPS));
        write_coefs(16'h8000);
        settings_used++;
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        wait_drained();
    endtask

    // A tap count of zero acts as one tap.
    task automatic test_tap_count_zero();
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'd0);
        write_reg(fircf_pkg::CFG_COEF_BASE, 16'h4000);
        settings_used++;
        send_sample(16'sh1234, 1'b0);
        send_sample(16'sh8000, 1'b1);
        wait_drained();
    endtask

    // Writes past the last coefficient must change nothing.
    task automatic test_bad_index();
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'd3);
        for (int k = fircf_pkg::CFG_COEF_BASE + fircf_pkg::NUM_COEF;
             k < 2 ** fircf_pkg::CFG_INDEX_BITS; k++)
            write_reg(fircf_pkg::cfg_index_t'(k), 16'($urandom));
        settings_used++;
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh2000, 1'b1);
        wait_drained();
    endtask

    // Tap count raised in the middle of a signal: the older samples still
    // sit in the delay line and enter the sums from the next beat on.
    task automatic test_mid_signal_taps();
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'd2);
        for (int c = 0; c < fircf_pkg::NUM_COEF; c++)
            write_reg(fircf_pkg::cfg_index_t'(fircf_pkg::CFG_COEF_BASE + c),
                      16'(1000 * (c + 1)));
        settings_used++;
        send_sample(16'sh0101, 1'b0);
        send_sample(16'sh0202, 1'b0);
        send_sample(16'shf303, 1'b0);
        wait_drained();
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'd6);
        settings_used++;
        send_sample(16'sh0404, 1'b0);
        send_sample(16'sh8505, 1'b1);
        wait_drained();
    endtask

    // No gaps and no stalls: tails of short signals back to back.
    task automatic test_back_to_back();
        steady = 1'b1;
        write_reg(fircf_pkg::CFG_TAP_COUNT, 16'd3);
        settings_used++;
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0fff, 1'b1);
        send_sample(16'sh8001, 1'b1);
        send_sample(16'sh7ffe, 1'b1);
        wait_drained();
        steady = 1'b0;
    endtask

    // Random settings, each followed by a few signals of random length.
    // Some phases end without the end flag, so the next setting lands in the
    // middle of a signal. Each setting waits for a drain, as do some signals.
    task automatic test_random_signals();
        int                  start;
        int                  phase;
        int                  n_sig;
        int                  len;
        fircf_pkg::tap_num_t taps;
        logic                eos;
        start = beats_sent;
        phase = 0;
        while (beats_sent - start < RANDOM_ITEMS)
        begin
            wait_drained();
            steady = ($urandom_range(0, 4) == 0);
            if (phase == 0)
                taps = fircf_pkg::tap_num_t'(TAPS);
            else if (phase == 1)
                taps = 3'd1;
            else
                taps = fircf_pkg::tap_num_t'($urandom_range(0, TAPS));
            // The upper bits of the data are not part of the count.
            write_reg(fircf_pkg::CFG_TAP_COUNT, (16'($urandom) & 16'hfff8) | 16'(taps));
            for (int c = 0; c < fircf_pkg::NUM_COEF; c++)
                if (phase < 2 || $urandom_range(0, 1) == 1)
                    write_reg(fircf_pkg::cfg_index_t'(fircf_pkg::CFG_COEF_BASE + c),
                              pick_q15());
            if ($urandom_range(0, 7) == 0)
                write_reg(fircf_pkg::cfg_index_t'(
                              $urandom_range(fircf_pkg::CFG_COEF_BASE + fircf_pkg::NUM_COEF,
                                             2 ** fircf_pkg::CFG_INDEX_BITS - 1)),
                          16'($urandom));
            settings_used++;
            n_sig = $urandom_range(1, 4);
            for (int s = 0; s < n_sig; s++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    eos = (k == len - 1) &&
                          !(s == n_sig - 1 && $urandom_range(0, 3) == 0);
                    send_sample(sample_t'(pick_q15()), eos);
                end
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            phase++;
        end
        steady = 1'b0;
        wait_drained();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        steady        = 1'b0;
        error_count   = 0;
        beats_sent    = 0;
        beats_checked = 0;
        signals_sent  = 0;
        settings_used = 1;
        cycle_count   = 0;
        reset_filter_model();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_defaults();
        test_extremes();
        test_tap_count_zero();
        test_bad_index();
        test_mid_signal_taps();
        test_back_to_back();
        test_random_signals();

        // Let any stray beat show up before the verdict.
        repeat (10) @(posedge clk);
        if (conv_expected.size() != 0)
        begin
            $error("%0d expected beats never arrived", conv_expected.size());
            error_count++;
        end

        $display("Covered %0d sample beats in %0d complete signals over %0d filter settings.",
                 beats_sent, signals_sent, settings_used);
        $display("Checked %0d result beats; %0d mismatches.", beats_checked, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
design/fircf_pkg.sv
design/fircf_taps.sv
design/fir_convolution_filter.sv
bench/fir_convolution_filter_test.sv
